// ----- hw/rtl/bltm_pkg.sv -----
// Package: sizes, command codes, status codes and sequencer states for the tape machine.
`default_nettype none
package bltm_pkg;
  localparam int PROG_DEPTH = 65536;
  localparam int TAPE_DEPTH = 32768;
  localparam int NEST_DEPTH = 64;
  localparam int CELL_BITS  = 8;
  localparam int PA_W  = $clog2(PROG_DEPTH);
  localparam int PL_W  = PA_W + 1;
  localparam int TA_W  = $clog2(TAPE_DEPTH);
  localparam int NA_W  = $clog2(NEST_DEPTH);
  localparam int NL_W  = NA_W + 1;

  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_ADD = 8'h2B;
  localparam logic [7:0] CH_SUB = 8'h2D;
  localparam logic [7:0] CH_OUT = 8'h2E;
  localparam logic [7:0] CH_IN  = 8'h2C;
  localparam logic [7:0] CH_OPN = 8'h5B;
  localparam logic [7:0] CH_CLS = 8'h5D;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FINISHED   = 3'd1;
  localparam logic [2:0] ST_UNBALANCED = 3'd2;
  localparam logic [2:0] ST_RANGE      = 3'd3;
  localparam logic [2:0] ST_NESTING    = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_EXEC, S_SCAN, S_SCANRD, S_RESULT
  } state_t;
endpackage
`default_nettype wire

// ----- hw/rtl/bracket_loop_tape_machine.sv -----
// Tape machine with program, tape and loop stack memories.
// Load word: result valid in the cycle after accept.
// Step: accept, fetch, execute, result, or accept then result for a stopped or ended
// program; every '[' scans for its match through scan and read states, one read a byte.
// Reset and every last-marked load sweep the tape clear, one cell a cycle, while
// no word is accepted.
`default_nettype none
module bracket_loop_tape_machine import bltm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       func,
  input  wire logic [7:0] prog_byte,
  input  wire logic       prog_last,
  input  wire logic [7:0] in_byte,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            input_taken,
  output logic [2:0]      status
);
  // memories
  logic [7:0]           prog_mem [PROG_DEPTH];
  logic [CELL_BITS-1:0] tape_mem [TAPE_DEPTH];
  logic [PL_W-1:0]      stack_mem [NEST_DEPTH];

  state_t state, state_next;
  logic [PL_W-1:0] plen, ip, scan, depth;
  logic [TA_W-1:0] tp, clr;
  logic [NL_W-1:0] lvl;
  logic [2:0]      rstat;
  logic            closed;
  logic [7:0]      prd;
  logic [CELL_BITS-1:0] tval;
  logic [PL_W-1:0] stk;
  logic [7:0]      ib;

  logic in_acc, res_acc;
  assign in_acc  = in_valid && !in_stall;
  assign res_acc = res_valid && !res_stall;
  assign in_stall = !(state == S_IDLE);

  // program memory read address
  logic [PA_W-1:0] prd_addr;
  always_comb begin
    prd_addr = (state == S_SCAN || state == S_SCANRD) ? scan[PA_W-1:0] : ip[PA_W-1:0];
  end
  always_ff @(posedge clk) begin
    prd <= prog_mem[prd_addr];
    tval <= tape_mem[tp];
    stk <= stack_mem[lvl[NA_W-1:0] - 1'b1];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (&clr) state_next = S_IDLE;
      S_IDLE: if (in_acc) begin
        if (!func) state_next = S_RESULT;
        else if (rstat != ST_OK || ip >= plen) state_next = S_RESULT;
        else state_next = S_FETCH;
      end
      S_FETCH: state_next = S_EXEC;
      S_EXEC: state_next = (prd == CH_OPN) ? S_SCAN : S_RESULT;
      S_SCAN: state_next = S_SCANRD;
      S_SCANRD: begin
        if (scan >= plen) state_next = S_RESULT;
        else if (prd == CH_CLS && depth == 1) state_next = S_RESULT;
        else state_next = S_SCAN;
      end
      S_RESULT: if (res_acc) state_next = (closed && rstat == ST_OK && clr == 0) ?
                                          S_CLEAR : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0; plen <= '0; ip <= '0; tp <= '0; lvl <= '0;
      rstat <= ST_OK; closed <= 1'b0; res_valid <= 1'b0;
    end else begin
      state <= state_next;
      // tape clearing sweep
      if (state == S_CLEAR) begin
        tape_mem[clr] <= '0;
        clr <= clr + 1'b1;
      end
      if (state == S_RESULT && res_acc) begin
        res_valid <= 1'b0;
        if (state_next == S_CLEAR) clr <= '0;
      end
      if (state == S_IDLE && in_acc) begin
        out_valid <= 1'b0; out_byte <= '0; input_taken <= 1'b0;
        ib <= in_byte;
        // zero only for a last-marked load: that starts the sweep
        clr <= (!func && prog_last) ? '0 : TA_W'(1);
        if (!func) begin
          logic [PL_W-1:0] l;
          l = closed ? '0 : plen;
          if (l < PL_W'(PROG_DEPTH)) begin
            prog_mem[l[PA_W-1:0]] <= prog_byte;
            l = l + 1'b1;
            status <= ST_OK;
          end else status <= ST_FULL;
          plen <= l;
          closed <= prog_last ? 1'b1 : (closed ? 1'b0 : closed);
          if (prog_last) begin
            ip <= '0; tp <= '0; lvl <= '0; rstat <= ST_OK;
          end
          res_valid <= 1'b1;
        end else if (rstat != ST_OK) begin
          status <= rstat; res_valid <= 1'b1;
        end else if (ip >= plen) begin
          rstat <= ST_FINISHED; status <= ST_FINISHED; res_valid <= 1'b1;
        end
      end
      // execute one command
      if (state == S_EXEC) begin
        logic [2:0] ns;
        ns = ST_OK;
        case (prd)
          CH_LT: if (tp == 0) ns = ST_RANGE; else tp <= tp - 1'b1;
          CH_GT: if ({1'b0, tp} + 1'b1 >= (TA_W+1)'(TAPE_DEPTH)) ns = ST_RANGE;
                 else tp <= tp + 1'b1;
          CH_ADD: tape_mem[tp] <= tval + 1'b1;
          CH_SUB: tape_mem[tp] <= tval - 1'b1;
          CH_OUT: begin out_valid <= 1'b1; out_byte <= tval[7:0]; end
          CH_IN: begin tape_mem[tp] <= CELL_BITS'(ib); input_taken <= 1'b1; end
          CH_CLS: begin
            if (lvl == 0) ns = ST_UNBALANCED;
            else if (tval != 0) ip <= stk + 1'b1;
            else begin lvl <= lvl - 1'b1; ip <= ip + 1'b1; end
          end
          default: ;
        endcase
        if (prd == CH_OPN) begin
          scan <= ip + 1'b1; depth <= PL_W'(1);
        end else begin
          if (ns == ST_OK && prd != CH_CLS) ip <= ip + 1'b1;
          rstat <= ns; status <= ns; res_valid <= 1'b1;
        end
      end
      if (state == S_SCAN) scan <= scan;
      // bracket match scan: prd holds byte at scan
      if (state == S_SCANRD) begin
        if (scan >= plen) begin
          rstat <= ST_UNBALANCED; status <= ST_UNBALANCED; res_valid <= 1'b1;
        end else if (prd == CH_CLS && depth == 1) begin
          res_valid <= 1'b1;
          if (tval == 0) begin
            ip <= scan + 1'b1; status <= ST_OK;
          end else if (lvl >= NL_W'(NEST_DEPTH)) begin
            rstat <= ST_NESTING; status <= ST_NESTING;
          end else begin
            stack_mem[lvl[NA_W-1:0]] <= ip; lvl <= lvl + 1'b1; ip <= ip + 1'b1;
            status <= ST_OK;
          end
        end else begin
          if (prd == CH_OPN) depth <= depth + 1'b1;
          else if (prd == CH_CLS) depth <= depth - 1'b1;
          scan <= scan + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/bltm_checker.sv -----
// Port-level checker for the tape machine, bound to the top level.
`default_nettype none
module bltm_checker import bltm_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire logic       out_valid,
  input wire logic       input_taken,
  input wire logic [2:0] status
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_stall) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status))
    else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(out_valid && input_taken)) else $error("two commands");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    res_valid && (out_valid || input_taken) |-> status == ST_OK)
    else $error("io with error");
endmodule
bind bracket_loop_tape_machine bltm_checker u_chk (.*);
`default_nettype wire

// ----- tb/bracket_loop_tape_machine_tb.sv -----
// Testbench for the bracket loop tape machine: random-gap driver, monitor and a scoreboard.
`timescale 1ns / 1ps
module bracket_loop_tape_machine_tb;
  import bltm_pkg::*;

  typedef struct {
    bit       func;
    bit [7:0] pbyte;
    bit       plast;
    bit [7:0] ibyte;
    bit       calm;   // no idling on either side while this word is in flight
    bit       drain;  // marker: hold off until every result is back
  } word_t;

  typedef struct {
    bit       ov;
    bit [7:0] ob;
    bit       it;
    bit [2:0] st;
  } reply_t;

  logic       clk = 0;
  logic       rst = 1;
  logic       in_valid = 0;
  logic       in_stall;
  logic       func = 0;
  logic [7:0] prog_byte = 0;
  logic       prog_last = 0;
  logic [7:0] in_byte = 0;
  logic       res_valid;
  logic       res_stall = 0;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       input_taken;
  logic [2:0] status;

  bracket_loop_tape_machine dut (.*);

  initial forever #5 clk = ~clk;

  // machine shadow state
  logic [7:0]    prog_mem [PROG_DEPTH];
  logic [7:0]    tape [TAPE_DEPTH];
  int unsigned   loop_stk [NEST_DEPTH];
  int unsigned   prog_len, ip, tp, lvl;
  logic [2:0]    run_st;
  bit            closed;

  word_t   pending [$];
  reply_t  expected [$];
  bit [7:0] prog_buf [$];
  int      errors = 0, words_in = 0, replies = 0, outs = 0;
  int      gap_cnt = 0, hold = 0;
  bit      in_acc = 0, res_acc = 0, quiet = 0;
  longint  cycles = 0;
  int      st_seen [8];

  function automatic int unsigned match_of(int unsigned pos);
    int unsigned depth;
    depth = 1;
    for (int unsigned i = pos + 1; i < prog_len; i++) begin
      if (prog_mem[i] == CH_OPN) depth++;
      else if (prog_mem[i] == CH_CLS) begin
        depth--;
        if (depth == 0) return i;
      end
    end
    return prog_len;
  endfunction

  function automatic void restart();
    foreach (tape[i]) tape[i] = '0;
    ip = 0; tp = 0; lvl = 0; run_st = ST_OK;
  endfunction

  // next result of the machine for one accepted word
  function automatic reply_t machine_next(word_t w);
    reply_t r;
    int unsigned nxt, m;
    logic [7:0] ch;
    r = '{0, 0, 0, ST_OK};
    if (!w.func) begin
      if (closed) begin
        prog_len = 0; closed = 0;
      end
      if (prog_len < PROG_DEPTH) begin
        prog_mem[prog_len] = w.pbyte; prog_len++;
      end else r.st = ST_FULL;
      if (w.plast) begin
        closed = 1; restart();
      end
    end else if (run_st != ST_OK) begin
      r.st = run_st;
    end else if (ip >= prog_len) begin
      run_st = ST_FINISHED; r.st = run_st;
    end else begin
      ch = prog_mem[ip];
      nxt = ip + 1;
      case (ch)
        CH_LT:  if (tp == 0) run_st = ST_RANGE; else tp--;
        CH_GT:  if (tp + 1 >= TAPE_DEPTH) run_st = ST_RANGE; else tp++;
        CH_ADD: tape[tp] = tape[tp] + 8'd1;
        CH_SUB: tape[tp] = tape[tp] - 8'd1;
        CH_OUT: begin
          r.ov = 1; r.ob = tape[tp];
        end
        CH_IN: begin
          tape[tp] = w.ibyte; r.it = 1;
        end
        CH_OPN: begin
          m = match_of(ip);
          if (m >= prog_len) run_st = ST_UNBALANCED;
          else if (tape[tp] == 0) nxt = m + 1;
          else if (lvl >= NEST_DEPTH) run_st = ST_NESTING;
          else begin
            loop_stk[lvl] = ip; lvl++;
          end
        end
        CH_CLS: begin
          if (lvl == 0) run_st = ST_UNBALANCED;
          else if (tape[tp] != 0) nxt = loop_stk[lvl - 1] + 1;
          else lvl--;
        end
        default: ;
      endcase
      if (run_st == ST_OK) ip = nxt;
      r.st = run_st;
    end
    return r;
  endfunction

  // monitor: accept words, predict, and check results
  always @(posedge clk) begin
    reply_t e;
    in_acc = !rst && in_valid && !in_stall;
    res_acc = !rst && res_valid && !res_stall;
    if (in_acc) begin
      expected.push_back(machine_next('{func, prog_byte, prog_last, in_byte, 0, 0}));
      words_in++;
    end
    if (res_acc) begin
      replies++;
      if (out_valid) outs++;
      st_seen[status]++;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with nothing expected, status %0d", status);
      end else begin
        e = expected.pop_front();
        if (out_valid !== e.ov || out_byte !== e.ob || input_taken !== e.it
            || status !== e.st) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result %0d exp ov=%0d ob=%h it=%0d st=%0d got ov=%b ob=%h it=%b st=%0d",
                     replies, e.ov, e.ob, e.it, e.st, out_valid, out_byte, input_taken, status);
        end
      end
    end
  end

  // driver: present words from the pending queue with random gaps
  always @(negedge clk) begin
    word_t w;
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !in_acc) begin
      // held word stays put
    end else if (gap_cnt > 0) begin
      gap_cnt--;
      in_valid <= 0;
    end else if (pending.size() != 0 && pending[0].drain) begin
      if (expected.size() == 0 && !in_valid) void'(pending.pop_front());
      in_valid <= 0;
    end else if (pending.size() != 0) begin
      w = pending.pop_front();
      func <= w.func; prog_byte <= w.pbyte; prog_last <= w.plast; in_byte <= w.ibyte;
      in_valid <= 1;
      quiet = w.calm;
      gap_cnt = w.calm ? 0 : $urandom_range(0, 16);
    end else begin
      in_valid <= 0;
    end
  end

  // result stall: a fresh wait is drawn per result
  always @(negedge clk) begin
    if (res_acc) hold = quiet ? 0 : $urandom_range(0, 16);
    if (hold > 0) begin
      res_stall <= 1;
      hold--;
    end else res_stall <= 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 6000000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) prog_buf.push_back(s[i]);
  endtask

  // queue the buffered program as loads, last mark on the final byte
  task automatic load_prog(bit calm);
    int n;
    n = prog_buf.size();
    for (int i = 0; i < n; i++)
      pending.push_back('{0, prog_buf[i], i == n - 1, 8'($urandom_range(0, 255)), calm, 0});
    prog_buf.delete();
  endtask

  task automatic add_steps(int n, bit calm);
    repeat (n) pending.push_back('{1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                   8'($urandom_range(0, 255)), calm, 0});
  endtask

  task automatic add_drain();
    pending.push_back('{0, 0, 0, 0, 0, 1});
  endtask

  task automatic rand_prog(int len);
    int depth;
    string pool;
    pool = "<>>>++-.,.";
    depth = 0;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: if (depth < 3) begin
          put_str("["); depth++;
        end
        1: if (depth > 0) begin
          put_str("-]"); depth--;
        end
        default: prog_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
      endcase
    end
    repeat (depth) put_str("]");
    // sometimes leave it broken
    if ($urandom_range(0, 5) == 0) put_str("[");
  endtask

  initial begin
    bit calm;
    // step with nothing loaded: empty program ends at once, then stays ended
    add_steps(2, 0);
    // no-op zero byte, random inputs, increment and decrement, output, right move, left edge
    prog_buf.push_back(8'h00);
    put_str(",.+.,-.>.<<");
    load_prog(0);
    pending.push_back('{1, 0, 0, 8'hFF, 0, 0});
    add_steps(13, 0);
    // close bracket with empty loop stack
    put_str("]"); load_prog(0); add_steps(2, 0);
    // open bracket with no match on a nonzero cell
    put_str("+["); load_prog(0); add_steps(3, 0);
    add_drain();
    // nesting deeper than the loop stack
    put_str("+");
    repeat (65) put_str("[");
    repeat (65) put_str("]");
    load_prog(1); add_steps(70, 1);
    // skip on zero cell, counted loop with output, then program end
    put_str("[+]+++[-.]."); load_prog(0); add_steps(25, 0);
    // random programs, mostly well-formed, with noise words in between
    for (int p = 0; p < 8; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      rand_prog($urandom_range(8, 40));
      load_prog(calm);
      for (int s = 0; s < 150; s++) begin
        if ($urandom_range(0, 19) == 0)
          pending.push_back('{0, 8'($urandom_range(0, 255)), 0,
                              8'($urandom_range(0, 255)), calm, 0});
        else add_steps(1, calm);
      end
      if (p == 3) add_drain();
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst = 0;
    while (pending.size() != 0 || in_valid || expected.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Run covered %0d words in, %0d results, %0d output bytes", words_in, replies, outs);
    $display("Status counts ok/fin/unbal/range/nest/full: %0d %0d %0d %0d %0d %0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4], st_seen[5]);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ----- bracket_loop_tape_machine.f -----
hw/rtl/bltm_pkg.sv
hw/rtl/bracket_loop_tape_machine.sv
hw/rtl/bltm_checker.sv
tb/bracket_loop_tape_machine_tb.sv
